### sv/bbc_pkg.sv
// shared constants for the blackbody color pipeline
package bbc_pkg;

  localparam int unsigned TEMP_W = 14;
  localparam int unsigned UV_FRAC = 32;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned MIX_W = 36;

  localparam logic [TEMP_W-1:0] T_LOW = 14'd1000;
  localparam logic [TEMP_W-1:0] T_HIGH = 14'd15000;

  // locus polynomials, coefficients scaled by 1e16
  localparam logic [DATA_W-1:0] NU0 = 64'd8601177570000000;
  localparam logic [DATA_W-1:0] NU1 = 64'd1541182540000;
  localparam logic [DATA_W-1:0] NU2 = 64'd1286412120;
  localparam logic [DATA_W-1:0] DU0 = 64'd10000000000000000;
  localparam logic [DATA_W-1:0] DU1 = 64'd8424202350000;
  localparam logic [DATA_W-1:0] DU2 = 64'd7081451630;
  localparam logic [DATA_W-1:0] NV0 = 64'd3173987260000000;
  localparam logic [DATA_W-1:0] NV1 = 64'd422806245000;
  localparam logic [DATA_W-1:0] NV2 = 64'd420481691;
  localparam logic [DATA_W-1:0] DV0 = 64'd10000000000000000;
  localparam logic [DATA_W-1:0] DV1 = 64'd289741816000;
  localparam logic [DATA_W-1:0] DV2 = 64'd1614560530;

  // linear srgb matrix scaled by 1e7, row by row
  localparam logic signed [26:0] K_RA = 27'sd32404542;
  localparam logic signed [26:0] K_RB = -27'sd15371385;
  localparam logic signed [26:0] K_RC = -27'sd4985314;
  localparam logic signed [26:0] K_GA = -27'sd9692660;
  localparam logic signed [26:0] K_GB = 27'sd18760108;
  localparam logic signed [26:0] K_GC = 27'sd415560;
  localparam logic signed [26:0] K_BA = 27'sd556434;
  localparam logic signed [26:0] K_BB = -27'sd2040259;
  localparam logic signed [26:0] K_BC = 27'sd10572252;

endpackage

### sv/blackbody_color_from_kelvin_core.sv
// blackbody color temperature to normalized linear srgb, fully pipelined
//
// usage:
//   s_axis carries one item per temperature in whole kelvin (tdata[15:0]);
//   values outside 1000..15000 saturate to the nearest bound
//   m_axis returns one item per input: red, green, blue in unsigned fixed
//   point with OUT_FRAC_BITS fraction bits, the largest component at 1.0
// dividers: the u,v divider has 32 one-bit steps, the normalizing divider
//   has OUT_FRAC_BITS + 2 steps
// throughput: one item per cycle while the skid register is empty
// reset: all valid bits clear, no item in flight, s_axis_tready is high
//   from reset on since the skid register starts empty
// stall: a skid register behind the output register takes the item that
//   arrives while m_axis is stalled; the whole pipeline then freezes and
//   s_axis_tready drops until the output moves again, nothing is lost
module blackbody_color_from_kelvin_core #(
  parameter int unsigned OUT_FRAC_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // temperature_k
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // red, green, blue
);

  localparam int unsigned DW = bbc_pkg::DATA_W;
  localparam int unsigned MW = bbc_pkg::MIX_W;
  localparam int unsigned UVN = bbc_pkg::UV_FRAC;
  localparam int unsigned NN = OUT_FRAC_BITS + 2;
  localparam int unsigned QW = OUT_FRAC_BITS + 2;
  localparam int unsigned S_M1 = 3 + UVN;
  localparam int unsigned S_N0 = S_M1 + 4;
  localparam int unsigned NS = S_N0 + NN;

  logic en;
  logic [NS-1:0] v_q;

  // front stages
  logic [bbc_pkg::TEMP_W-1:0] t_d, t_q;
  logic [2*bbc_pkg::TEMP_W-1:0] t2_q;
  logic [DW-1:0] pnu1_q, pnu2_q, pdu1_q, pdu2_q, pnv1_q, pnv2_q, pdv1_q, pdv2_q;
  logic [DW-1:0] nu_q, du_q, nv_q, dv_q;

  // u,v divider
  logic [DW-1:0] ur_d [UVN];
  logic [DW-1:0] ur_q [UVN];
  logic [DW-1:0] ud_q [UVN];
  logic [UVN-1:0] uq_d [UVN];
  logic [UVN-1:0] uq_q [UVN];
  logic [DW-1:0] vr_d [UVN];
  logic [DW-1:0] vr_q [UVN];
  logic [DW-1:0] vd_q [UVN];
  logic [UVN-1:0] vq_d [UVN];
  logic [UVN-1:0] vq_q [UVN];

  // color mix
  logic [MW-1:0] uq36, vq36;
  logic signed [MW-1:0] a_q, b_q, c_q;
  logic signed [DW-1:0] prod_q [9];
  logic signed [DW-1:0] sum_d [3];
  logic [DW-1:0] rgb_q [3];
  logic [DW-1:0] rgbm_q [3];
  logic [DW-1:0] max_d, max_q;

  // normalizing divider
  logic [DW-1:0] nr_d [NN][3];
  logic [DW-1:0] nr_q [NN][3];
  logic [QW-1:0] nq_d [NN][3];
  logic [QW-1:0] nq_q [NN][3];
  logic [DW-1:0] nm_q [NN];
  logic nz_q [NN];

  // output register and skid
  logic [QW:0] one_w;
  logic [15:0] res_d [3];
  logic [47:0] res_pack;
  logic o_v_q, sk_v_q;
  logic [47:0] o_q, sk_q;

  assign en = !sk_v_q;
  assign s_axis_tready = en;

  always_comb begin
    priority if (s_axis_tdata < 16'(bbc_pkg::T_LOW)) begin
      t_d = bbc_pkg::T_LOW;
    end else if (s_axis_tdata > 16'(bbc_pkg::T_HIGH)) begin
      t_d = bbc_pkg::T_HIGH;
    end else begin
      t_d = s_axis_tdata[bbc_pkg::TEMP_W-1:0];
    end
  end

  // one quotient bit per stage
  always_comb begin
    logic [DW-1:0] r2;
    r2 = {nu_q[DW-2:0], 1'b0};
    ur_d[0] = (r2 >= du_q) ? r2 - du_q : r2;
    uq_d[0] = UVN'(r2 >= du_q);
    r2 = {nv_q[DW-2:0], 1'b0};
    vr_d[0] = (r2 >= dv_q) ? r2 - dv_q : r2;
    vq_d[0] = UVN'(r2 >= dv_q);
    for (int i = 1; i < UVN; i++) begin
      r2 = {ur_q[i-1][DW-2:0], 1'b0};
      ur_d[i] = (r2 >= ud_q[i-1]) ? r2 - ud_q[i-1] : r2;
      uq_d[i] = {uq_q[i-1][UVN-2:0], r2 >= ud_q[i-1]};
      r2 = {vr_q[i-1][DW-2:0], 1'b0};
      vr_d[i] = (r2 >= vd_q[i-1]) ? r2 - vd_q[i-1] : r2;
      vq_d[i] = {vq_q[i-1][UVN-2:0], r2 >= vd_q[i-1]};
    end
  end

  assign uq36 = MW'(uq_q[UVN-1]);
  assign vq36 = MW'(vq_q[UVN-1]);

  always_comb begin
    logic [DW-1:0] r2;
    for (int k = 0; k < 3; k++) begin
      sum_d[k] = prod_q[3*k] + prod_q[3*k+1] + prod_q[3*k+2];
    end
    max_d = rgb_q[0];
    if (rgb_q[1] > max_d) begin
      max_d = rgb_q[1];
    end
    if (rgb_q[2] > max_d) begin
      max_d = rgb_q[2];
    end
    for (int k = 0; k < 3; k++) begin
      nr_d[0][k] = (rgbm_q[k] >= max_q) ? rgbm_q[k] - max_q : rgbm_q[k];
      nq_d[0][k] = QW'(rgbm_q[k] >= max_q);
    end
    for (int j = 1; j < NN; j++) begin
      for (int k = 0; k < 3; k++) begin
        r2 = {nr_q[j-1][k][DW-2:0], 1'b0};
        nr_d[j][k] = (r2 >= nm_q[j-1]) ? r2 - nm_q[j-1] : r2;
        nq_d[j][k] = {nq_q[j-1][k][QW-2:0], r2 >= nm_q[j-1]};
      end
    end
  end

  // round half up, every component at 1.0 when nothing is lit
  assign one_w = (QW + 1)'(1) << OUT_FRAC_BITS;
  always_comb begin
    logic [QW:0] rnd;
    for (int k = 0; k < 3; k++) begin
      rnd = ((QW + 1)'(nq_q[NN-1][k]) + (QW + 1)'(1)) >> 1;
      res_d[k] = nz_q[NN-1] ? 16'(one_w) : 16'(rnd);
    end
  end
  assign res_pack = {res_d[2], res_d[1], res_d[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q <= t_d;
      t2_q <= (2*bbc_pkg::TEMP_W)'(t_d) * (2*bbc_pkg::TEMP_W)'(t_d);

      pnu1_q <= bbc_pkg::NU1 * DW'(t_q);
      pnu2_q <= bbc_pkg::NU2 * DW'(t2_q);
      pdu1_q <= bbc_pkg::DU1 * DW'(t_q);
      pdu2_q <= bbc_pkg::DU2 * DW'(t2_q);
      pnv1_q <= bbc_pkg::NV1 * DW'(t_q);
      pnv2_q <= bbc_pkg::NV2 * DW'(t2_q);
      pdv1_q <= bbc_pkg::DV1 * DW'(t_q);
      pdv2_q <= bbc_pkg::DV2 * DW'(t2_q);

      nu_q <= bbc_pkg::NU0 + pnu1_q + pnu2_q;
      du_q <= bbc_pkg::DU0 + pdu1_q + pdu2_q;
      nv_q <= bbc_pkg::NV0 + pnv1_q + pnv2_q;
      dv_q <= bbc_pkg::DV0 + pdv2_q - pdv1_q;

      ud_q[0] <= du_q;
      vd_q[0] <= dv_q;
      for (int i = 1; i < UVN; i++) begin
        ud_q[i] <= ud_q[i-1];
        vd_q[i] <= vd_q[i-1];
      end
      for (int i = 0; i < UVN; i++) begin
        ur_q[i] <= ur_d[i];
        uq_q[i] <= uq_d[i];
        vr_q[i] <= vr_d[i];
        vq_q[i] <= vq_d[i];
      end

      a_q <= signed'(uq36 + (uq36 << 1));
      b_q <= signed'(vq36 << 1);
      c_q <= signed'((MW'(4) << UVN) - uq36 - (vq36 << 3) - (vq36 << 1));

      prod_q[0] <= DW'(bbc_pkg::K_RA) * DW'(a_q);
      prod_q[1] <= DW'(bbc_pkg::K_RB) * DW'(b_q);
      prod_q[2] <= DW'(bbc_pkg::K_RC) * DW'(c_q);
      prod_q[3] <= DW'(bbc_pkg::K_GA) * DW'(a_q);
      prod_q[4] <= DW'(bbc_pkg::K_GB) * DW'(b_q);
      prod_q[5] <= DW'(bbc_pkg::K_GC) * DW'(c_q);
      prod_q[6] <= DW'(bbc_pkg::K_BA) * DW'(a_q);
      prod_q[7] <= DW'(bbc_pkg::K_BB) * DW'(b_q);
      prod_q[8] <= DW'(bbc_pkg::K_BC) * DW'(c_q);

      for (int k = 0; k < 3; k++) begin
        rgb_q[k] <= sum_d[k][DW-1] ? '0 : DW'(sum_d[k]);
        rgbm_q[k] <= rgb_q[k];
      end
      max_q <= max_d;

      nm_q[0] <= max_q;
      nz_q[0] <= (max_q == '0);
      for (int j = 1; j < NN; j++) begin
        nm_q[j] <= nm_q[j-1];
        nz_q[j] <= nz_q[j-1];
      end
      for (int j = 0; j < NN; j++) begin
        for (int k = 0; k < 3; k++) begin
          nr_q[j][k] <= nr_d[j][k];
          nq_q[j][k] <= nq_d[j][k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
      sk_v_q <= 1'b0;
    end else begin
      if (!o_v_q || m_axis_tready) begin
        if (sk_v_q) begin
          o_v_q <= 1'b1;
          sk_v_q <= 1'b0;
        end else begin
          o_v_q <= v_q[NS-1];
        end
      end else if (v_q[NS-1] && en) begin
        sk_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!o_v_q || m_axis_tready) begin
      o_q <= sk_v_q ? sk_q : res_pack;
    end else if (en) begin
      sk_q <= res_pack;
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata = o_q;

  a_skid_needs_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |-> o_v_q) else $error("skid holds an item behind an empty output");

  a_skid_refills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_v_q && m_axis_tready && sk_v_q) |=> (o_v_q && !sk_v_q))
    else $error("skid item not moved to output");

  if (OUT_FRAC_BITS <= 15) begin : g_norm_chk
    a_max_is_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid |-> (m_axis_tdata[15:0] == 16'(one_w) ||
                         m_axis_tdata[31:16] == 16'(one_w) ||
                         m_axis_tdata[47:32] == 16'(one_w)))
      else $error("no component at full scale");
  end

endmodule
